[src/riff_wave_chunk_parser_macros.svh]
// assertion macros for the riff wave chunk parser
`ifndef RIFF_WAVE_CHUNK_PARSER_MACROS_SVH
`define RIFF_WAVE_CHUNK_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RWCP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RWCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/rwcp_pkg.sv]
// types and constants shared by the riff wave chunk parser
`default_nettype none

package rwcp_pkg;

	typedef enum logic [2:0] {
		PH_RIFF,
		PH_RSIZE,
		PH_WAVE,
		PH_ID,
		PH_SIZE,
		PH_PAYLOAD,
		PH_PAD,
		PH_STOP
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_NOT_RIFF,
		ST_NOT_WAVE,
		ST_MISSING,
		ST_FMT_SHORT,
		ST_NOT_PCM
	} status_t;

	typedef enum logic [1:0] {
		KIND_OTHER,
		KIND_FORMAT,
		KIND_AUDIO
	} kind_t;

	localparam logic [31:0] MAGIC_RIFF  = 32'h5249_4646;
	localparam logic [31:0] MAGIC_WAVE  = 32'h5741_5645;
	localparam logic [31:0] ID_FMT      = 32'h666d_7420;
	localparam logic [31:0] ID_DATA     = 32'h6461_7461;
	localparam logic [31:0] MIN_FMT_LEN = 32'd18;
	localparam logic [15:0] PCM_TAG     = 16'd1;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  field_count;
		logic [31:0] id_shift;
		logic [31:0] size_accum;
		logic [31:0] payload_left;
		logic        seen_format;
		logic        seen_audio;
		logic [31:0] format_length;
		logic [15:0] format_tag;
		status_t     error_code;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase: PH_RIFF,
		field_count: 2'd0,
		id_shift: 32'd0,
		size_accum: 32'd0,
		payload_left: 32'd0,
		seen_format: 1'b0,
		seen_audio: 1'b0,
		format_length: 32'd0,
		format_tag: 16'd0,
		error_code: ST_OK
	};

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [31:0] offset;
		status_t     status;
		logic        done;
	} result_t;

endpackage

`default_nettype wire

[src/rwcp_channels.sv]
// valid/ready channel interfaces for the wave byte input and the parse result
`default_nettype none

interface rwcp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source(output valid, output in_byte, output in_last, input ready);
	modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

interface rwcp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_kind;
	logic [7:0]  out_byte;
	logic [31:0] out_offset;
	logic [2:0]  out_status;
	logic        out_done;

	modport source(output valid, output out_kind, output out_byte, output out_offset,
		output out_status, output out_done, input ready);
	modport sink(input valid, input out_kind, input out_byte, input out_offset,
		input out_status, input out_done, output ready);
endinterface

`default_nettype wire

[src/rwcp_step.sv]
// next-state and result logic for one byte of the wave stream
`default_nettype none

module rwcp_step (
	input  var rwcp_pkg::state_t  st,
	input  var logic [7:0]        in_byte,
	input  var logic              in_last,
	output rwcp_pkg::state_t      st_nx,
	output rwcp_pkg::result_t     res
);

	logic [1:0]  cnt_nx;
	logic [31:0] id_nx;
	logic [31:0] size_nx;
	logic [31:0] offset;
	logic [31:0] left_nx;

	// phase after a chunk ends: stop once both chunks are known
	function automatic rwcp_pkg::phase_t chunk_end(input logic fmt, input logic aud);
		return (fmt && aud) ? rwcp_pkg::PH_STOP : rwcp_pkg::PH_ID;
	endfunction

	assign cnt_nx  = st.field_count + 2'd1;
	assign id_nx   = {st.id_shift[23:0], in_byte};
	assign size_nx = {in_byte, st.size_accum[31:8]};
	assign offset  = st.size_accum - st.payload_left;
	assign left_nx = st.payload_left - 32'd1;

	always_comb begin
		st_nx      = st;
		res.kind   = rwcp_pkg::KIND_OTHER;
		res.data   = in_byte;
		res.offset = 32'd0;
		res.done   = in_last;

		unique case (st.phase) inside
			rwcp_pkg::PH_RIFF, rwcp_pkg::PH_WAVE, rwcp_pkg::PH_ID: begin
				st_nx.id_shift    = id_nx;
				st_nx.field_count = cnt_nx;
				if (cnt_nx == 2'd0) begin
					if (st.phase == rwcp_pkg::PH_RIFF) begin
						if (id_nx != rwcp_pkg::MAGIC_RIFF) begin
							st_nx.error_code = rwcp_pkg::ST_NOT_RIFF;
							st_nx.phase      = rwcp_pkg::PH_STOP;
						end else begin
							st_nx.phase = rwcp_pkg::PH_RSIZE;
						end
					end else if (st.phase == rwcp_pkg::PH_WAVE) begin
						if (id_nx != rwcp_pkg::MAGIC_WAVE) begin
							st_nx.error_code = rwcp_pkg::ST_NOT_WAVE;
							st_nx.phase      = rwcp_pkg::PH_STOP;
						end else begin
							st_nx.phase = rwcp_pkg::PH_ID;
						end
					end else begin
						st_nx.phase = rwcp_pkg::PH_SIZE;
					end
				end
			end
			rwcp_pkg::PH_RSIZE, rwcp_pkg::PH_SIZE: begin
				st_nx.size_accum  = size_nx;
				st_nx.field_count = cnt_nx;
				if (cnt_nx == 2'd0) begin
					if (st.phase == rwcp_pkg::PH_RSIZE) begin
						st_nx.phase = rwcp_pkg::PH_WAVE;
					end else begin
						if (st.id_shift == rwcp_pkg::ID_FMT) begin
							st_nx.seen_format   = 1'b1;
							st_nx.format_length = size_nx;
							st_nx.format_tag    = 16'd0;
						end else if (st.id_shift == rwcp_pkg::ID_DATA) begin
							st_nx.seen_audio = 1'b1;
						end
						st_nx.payload_left = size_nx;
						if (size_nx == 32'd0) begin
							st_nx.phase = chunk_end(st_nx.seen_format, st_nx.seen_audio);
						end else begin
							st_nx.phase = rwcp_pkg::PH_PAYLOAD;
						end
					end
				end
			end
			rwcp_pkg::PH_PAYLOAD: begin
				res.offset = offset;
				if (st.id_shift == rwcp_pkg::ID_FMT) begin
					res.kind = rwcp_pkg::KIND_FORMAT;
					if (offset == 32'd0) begin
						st_nx.format_tag[7:0] = in_byte;
					end else if (offset == 32'd1) begin
						st_nx.format_tag[15:8] = in_byte;
					end
				end else if (st.id_shift == rwcp_pkg::ID_DATA) begin
					res.kind = rwcp_pkg::KIND_AUDIO;
				end
				st_nx.payload_left = left_nx;
				if (left_nx == 32'd0) begin
					// odd size leaves one pad byte
					if (st.size_accum[0]) begin
						st_nx.phase = rwcp_pkg::PH_PAD;
					end else begin
						st_nx.phase       = chunk_end(st.seen_format, st.seen_audio);
						st_nx.field_count = 2'd0;
					end
				end
			end
			rwcp_pkg::PH_PAD: begin
				st_nx.phase       = chunk_end(st.seen_format, st.seen_audio);
				st_nx.field_count = 2'd0;
			end
			rwcp_pkg::PH_STOP: begin
			end
			default: begin
			end
		endcase

		res.status = st_nx.error_code;
		if (in_last) begin
			if (st_nx.error_code != rwcp_pkg::ST_OK) begin
				res.status = st_nx.error_code;
			end else if (st_nx.phase == rwcp_pkg::PH_RIFF) begin
				res.status = rwcp_pkg::ST_NOT_RIFF;
			end else if (st_nx.phase == rwcp_pkg::PH_RSIZE
					|| st_nx.phase == rwcp_pkg::PH_WAVE) begin
				res.status = rwcp_pkg::ST_NOT_WAVE;
			end else if (!(st_nx.seen_format && st_nx.seen_audio)) begin
				res.status = rwcp_pkg::ST_MISSING;
			end else if (st_nx.format_length < rwcp_pkg::MIN_FMT_LEN) begin
				res.status = rwcp_pkg::ST_FMT_SHORT;
			end else if (st_nx.format_tag != rwcp_pkg::PCM_TAG) begin
				res.status = rwcp_pkg::ST_NOT_PCM;
			end else begin
				res.status = rwcp_pkg::ST_OK;
			end
			// rearm for the next file
			st_nx = rwcp_pkg::STATE_RESET;
		end
	end

endmodule

`default_nettype wire

[src/riff_wave_chunk_parser.sv]
// top level of the riff wave chunk parser: input stage, parser state, result stage
`default_nettype none

`include "riff_wave_chunk_parser_macros.svh"

// Streaming WAV container parser. Bytes of one file enter on the wav channel, one item
// per byte, with in_last set on the final byte; every byte yields exactly one result item
// on the res channel, in order. The parser checks the RIFF magic, skips the RIFF size,
// checks the WAVE magic and then walks chunks (4-byte ID, little-endian 32-bit size,
// payload, one pad byte after an odd size). Payload bytes of the fmt chunk come out with
// kind 1, those of the data chunk with kind 2, everything else with kind 0; out_offset is
// the byte's position inside its chunk payload. Once both chunks have been walked, further
// bytes are passed through as kind 0. On the last byte out_done is set and out_status
// carries the final verdict (ok, not RIFF, not WAVE, missing chunk, fmt shorter than
// 18 bytes, format tag not PCM); the parser then rearms for the next file with no gap.
// Throughput is one byte per clock cycle, sustained while the res channel takes results: the
// only loop is the update of the parser state register from the byte held in the input
// stage. A byte passes the input stage, then the result stage, where result valid rises;
// the result stage is loaded only when it is empty or being drained.
// A stalled res channel holds the result stage and one more byte in the input stage
// before wav.ready drops.
module riff_wave_chunk_parser (
	input  var logic      clk,
	input  var logic      arst_n,
	rwcp_byte_if.sink     wav,
	rwcp_result_if.source res
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// parser state and result stage
	rwcp_pkg::state_t  st_q;
	rwcp_pkg::state_t  st_nx;
	rwcp_pkg::result_t step_res;
	rwcp_pkg::result_t res_s2;
	logic              valid_s2;

	// the input stage moves on when the result stage is empty or being drained
	logic adv;

	assign adv       = valid_s1 && (!valid_s2 || res.ready);
	assign wav.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (wav.ready) begin
			valid_s1 <= wav.valid;
		end
	end

	// byte payload, no reset needed
	always_ff @(posedge clk) begin
		if (wav.ready && wav.valid) begin
			byte_s1 <= wav.in_byte;
			last_s1 <= wav.in_last;
		end
	end

	rwcp_step u_step (
		.st      (st_q),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.st_nx   (st_nx),
		.res     (step_res)
	);

	// parser state advances once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rwcp_pkg::STATE_RESET;
		end else if (adv) begin
			st_q <= st_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= step_res;
		end
	end

	assign res.valid      = valid_s2;
	assign res.out_kind   = res_s2.kind;
	assign res.out_byte   = res_s2.data;
	assign res.out_offset = res_s2.offset;
	assign res.out_status = res_s2.status;
	assign res.out_done   = res_s2.done;

	// a last byte leaves the parser rearmed
	`RWCP_ASSERT_NEXT(a_rearm_after_last, adv && last_s1,
		st_q.phase == rwcp_pkg::PH_RIFF && !st_q.seen_format && !st_q.seen_audio,
		"parser not rearmed after last byte")

	// a header error always parks the parser
	`RWCP_ASSERT_NOW(a_error_stops, st_q.error_code != rwcp_pkg::ST_OK,
		st_q.phase == rwcp_pkg::PH_STOP, "error code set outside stop phase")

	// chunk payload is only tagged while no error is pending
	`RWCP_ASSERT_NOW(a_payload_ok, valid_s2 && res_s2.kind != rwcp_pkg::KIND_OTHER
		&& !res_s2.done, res_s2.status == rwcp_pkg::ST_OK,
		"tagged payload byte carries an error status")

	// a held input byte is not dropped while the result stage is blocked
	`RWCP_ASSERT_NEXT(a_input_held, valid_s1 && !adv, valid_s1,
		"input stage lost a byte under stall")

endmodule

`default_nettype wire

[sim/tb.sv]
// testbench for the riff wave chunk parser: random wave files against a byte-level predictor
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// byte-level predictor of the parser plus the queue of results it still owes
	class wave_scoreboard;
		rwcp_pkg::result_t pending[$];
		int unsigned       failures;

		rwcp_pkg::phase_t  ph;
		logic [1:0]        field_idx;
		logic [31:0]       id_word;
		logic [31:0]       size_word;
		logic [31:0]       bytes_left;
		bit                have_fmt;
		bit                have_data;
		logic [31:0]       fmt_len;
		logic [15:0]       fmt_code;
		rwcp_pkg::status_t err;

		function new();
			failures = 0;
			clear_parse();
		endfunction

		function void clear_parse();
			ph = rwcp_pkg::PH_RIFF;
			field_idx = 2'd0;
			id_word = '0;
			size_word = '0;
			bytes_left = '0;
			have_fmt = 1'b0;
			have_data = 1'b0;
			fmt_len = '0;
			fmt_code = '0;
			err = rwcp_pkg::ST_OK;
		endfunction

		// end of a chunk: walk on, or stop once both chunks are known
		function void close_chunk();
			if (have_fmt && have_data)
				ph = rwcp_pkg::PH_STOP;
			else
				ph = rwcp_pkg::PH_ID;
			field_idx = 2'd0;
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			rwcp_pkg::result_t r;
			logic [31:0]       pos;
			rwcp_pkg::status_t st;
			r.kind = rwcp_pkg::KIND_OTHER;
			r.data = b;
			r.offset = '0;
			r.done = last;
			case (ph)
				rwcp_pkg::PH_RIFF, rwcp_pkg::PH_WAVE, rwcp_pkg::PH_ID: begin
					id_word = {id_word[23:0], b};
					field_idx = field_idx + 2'd1;
					if (field_idx == 2'd0) begin
						if (ph == rwcp_pkg::PH_RIFF) begin
							if (id_word != rwcp_pkg::MAGIC_RIFF) begin
								err = rwcp_pkg::ST_NOT_RIFF;
								ph = rwcp_pkg::PH_STOP;
							end else begin
								ph = rwcp_pkg::PH_RSIZE;
							end
						end else if (ph == rwcp_pkg::PH_WAVE) begin
							if (id_word != rwcp_pkg::MAGIC_WAVE) begin
								err = rwcp_pkg::ST_NOT_WAVE;
								ph = rwcp_pkg::PH_STOP;
							end else begin
								ph = rwcp_pkg::PH_ID;
							end
						end else begin
							ph = rwcp_pkg::PH_SIZE;
						end
					end
				end
				rwcp_pkg::PH_RSIZE, rwcp_pkg::PH_SIZE: begin
					size_word = {b, size_word[31:8]};
					field_idx = field_idx + 2'd1;
					if (field_idx == 2'd0) begin
						if (ph == rwcp_pkg::PH_RSIZE) begin
							ph = rwcp_pkg::PH_WAVE;
						end else begin
							if (id_word == rwcp_pkg::ID_FMT) begin
								have_fmt = 1'b1;
								fmt_len = size_word;
								fmt_code = '0;
							end else if (id_word == rwcp_pkg::ID_DATA) begin
								have_data = 1'b1;
							end
							bytes_left = size_word;
							if (bytes_left == 0)
								close_chunk();
							else
								ph = rwcp_pkg::PH_PAYLOAD;
						end
					end
				end
				rwcp_pkg::PH_PAYLOAD: begin
					pos = size_word - bytes_left;
					r.offset = pos;
					if (id_word == rwcp_pkg::ID_FMT) begin
						r.kind = rwcp_pkg::KIND_FORMAT;
						if (pos == 0)
							fmt_code[7:0] = b;
						else if (pos == 1)
							fmt_code[15:8] = b;
					end else if (id_word == rwcp_pkg::ID_DATA) begin
						r.kind = rwcp_pkg::KIND_AUDIO;
					end
					bytes_left = bytes_left - 1;
					if (bytes_left == 0) begin
						if (size_word[0])
							ph = rwcp_pkg::PH_PAD;
						else
							close_chunk();
					end
				end
				rwcp_pkg::PH_PAD: begin
					close_chunk();
				end
				default: begin
				end
			endcase
			st = err;
			if (last) begin
				if (err != rwcp_pkg::ST_OK)
					st = err;
				else if (ph == rwcp_pkg::PH_RIFF)
					st = rwcp_pkg::ST_NOT_RIFF;
				else if (ph == rwcp_pkg::PH_RSIZE || ph == rwcp_pkg::PH_WAVE)
					st = rwcp_pkg::ST_NOT_WAVE;
				else if (!(have_fmt && have_data))
					st = rwcp_pkg::ST_MISSING;
				else if (fmt_len < rwcp_pkg::MIN_FMT_LEN)
					st = rwcp_pkg::ST_FMT_SHORT;
				else if (fmt_code != rwcp_pkg::PCM_TAG)
					st = rwcp_pkg::ST_NOT_PCM;
				else
					st = rwcp_pkg::ST_OK;
			end
			r.status = st;
			pending.insert(pending.size(), r);
			if (last)
				clear_parse();
		endfunction

		function void check_result(rwcp_pkg::result_t got);
			rwcp_pkg::result_t want;
			if (pending.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result item: kind %0d byte %02h offset %0d status %0d done %0d",
						got.kind, got.data, got.offset, got.status, got.done);
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind || got.data !== want.data || got.offset !== want.offset ||
					got.status !== want.status || got.done !== want.done) begin
				failures++;
				if (failures <= 10) begin
					$display("mismatch: expected kind %0d byte %02h offset %0d status %0d done %0d",
						want.kind, want.data, want.offset, want.status, want.done);
					$display("          got      kind %0d byte %02h offset %0d status %0d done %0d",
						got.kind, got.data, got.offset, got.status, got.done);
				end
			end
		endfunction
	endclass

	// generous bound for the slowest idling regime
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PHASE_ITEMS = 275;

	logic clk;
	logic arst_n;

	rwcp_byte_if   wav_ch ();
	rwcp_result_if res_ch ();

	riff_wave_chunk_parser dut (
		.clk   (clk),
		.arst_n(arst_n),
		.wav   (wav_ch),
		.res   (res_ch)
	);

	wave_scoreboard sb = new();

	// bytes of the wave file being assembled, sent in order with last on the final one
	logic [7:0]        file_bytes[$];
	int unsigned       items_sent;
	int unsigned       idle_pct;
	int unsigned       stall_pct;
	int unsigned       cycle_count;
	rwcp_pkg::result_t seen_result;

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------- file builders

	// append one byte to the file
	function automatic void put_byte(input logic [7:0] b);
		file_bytes.insert(file_bytes.size(), b);
	endfunction

	// four-character codes go out first character first
	function automatic void put_tag(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			put_byte(w[i*8 +: 8]);
	endfunction

	// sizes are little endian
	function automatic void put_size(input logic [31:0] s);
		for (int i = 0; i < 4; i++)
			put_byte(s[i*8 +: 8]);
	endfunction

	// payload plus pad byte after an odd size; a format body mostly starts with the pcm tag
	function automatic void put_chunk(input logic [31:0] id, input int unsigned len,
			input bit fmt_body);
		bit pcm;
		pcm = ($urandom_range(9) < 8);
		put_tag(id);
		put_size(len);
		for (int unsigned i = 0; i < len; i++) begin
			if (fmt_body && pcm && i == 0)
				put_byte(rwcp_pkg::PCM_TAG[7:0]);
			else if (fmt_body && pcm && i == 1)
				put_byte(rwcp_pkg::PCM_TAG[15:8]);
			else
				put_byte(8'($urandom));
		end
		if (len % 2 != 0)
			put_byte(8'($urandom));
	endfunction

	// format sizes cluster around the 18-byte minimum
	function automatic int unsigned pick_fmt_len();
		case ($urandom_range(5))
			0: return 16;
			1: return 17;
			2: return 18;
			3: return 19;
			4: return 20;
			default: return $urandom_range(40);
		endcase
	endfunction

	// unknown chunk id: fully random or one bit away from the data id
	function automatic logic [31:0] junk_id();
		if ($urandom_range(1) == 0)
			return $urandom;
		return rwcp_pkg::ID_DATA ^ (32'h1 << $urandom_range(31));
	endfunction

	function automatic void build_wave_file();
		int unsigned roll;
		int unsigned cut;
		bit          with_fmt;
		bit          with_data;
		bit          swap;
		file_bytes.delete();
		roll = $urandom_range(99);
		if (roll < 6) begin
			// plain noise
			repeat ($urandom_range(1, 12))
				put_byte(8'($urandom));
		end else if (roll < 12) begin
			// wave magic with a bit flipped, sometimes the riff magic too, then a few stray bytes
			if ($urandom_range(1) == 0)
				put_tag(rwcp_pkg::MAGIC_RIFF ^ (32'h1 << $urandom_range(31)));
			else
				put_tag(rwcp_pkg::MAGIC_RIFF);
			put_size($urandom);
			put_tag(rwcp_pkg::MAGIC_WAVE ^ (32'h1 << $urandom_range(31)));
			repeat ($urandom_range(4))
				put_byte(8'($urandom));
		end else begin
			put_tag(rwcp_pkg::MAGIC_RIFF);
			put_size($urandom);
			put_tag(rwcp_pkg::MAGIC_WAVE);
			with_fmt = ($urandom_range(9) != 0);
			with_data = ($urandom_range(9) != 0);
			swap = ($urandom_range(3) == 0);
			if ($urandom_range(3) == 0)
				put_chunk(junk_id(), $urandom_range(9), 1'b0);
			if (with_fmt && !swap) begin
				put_chunk(rwcp_pkg::ID_FMT, pick_fmt_len(), 1'b1);
				// a second format chunk overrides the first
				if ($urandom_range(5) == 0)
					put_chunk(rwcp_pkg::ID_FMT, pick_fmt_len(), 1'b1);
			end
			if ($urandom_range(11) == 0) begin
				// chunk with a huge declared size, cut off by the end of the file
				case ($urandom_range(2))
					0: put_tag(rwcp_pkg::ID_FMT);
					1: put_tag(rwcp_pkg::ID_DATA);
					default: put_tag(junk_id());
				endcase
				put_size($urandom);
				repeat ($urandom_range(8))
					put_byte(8'($urandom));
				return;
			end
			if ($urandom_range(5) == 0)
				put_chunk(junk_id(), $urandom_range(5), 1'b0);
			if (with_data)
				put_chunk(rwcp_pkg::ID_DATA, $urandom_range(12), 1'b0);
			if (with_fmt && swap)
				put_chunk(rwcp_pkg::ID_FMT, pick_fmt_len(), 1'b1);
			// bytes past the walk are passed through as ignored
			repeat ($urandom_range(5))
				put_byte(8'($urandom));
			// sometimes the file ends early, anywhere
			if ($urandom_range(9) == 0) begin
				cut = $urandom_range(1, file_bytes.size() - 1);
				while (file_bytes.size() > cut)
					void'(file_bytes.pop_back());
			end
		end
	endfunction

	// ---------------------------------------------------------------- drivers

	// one item on the byte channel; valid stays high across back-to-back items
	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			wav_ch.valid <= 1'b0;
			@(negedge clk);
		end
		wav_ch.valid <= 1'b1;
		wav_ch.in_byte <= b;
		wav_ch.in_last <= last;
		@(posedge clk);
		while (!wav_ch.ready)
			@(posedge clk);
		sb.note_byte(b, last);
		items_sent++;
	endtask

	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
	endtask

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk)
		res_ch.ready <= ($urandom_range(99) >= stall_pct);

	// every accepted result goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			seen_result.kind = rwcp_pkg::kind_t'(res_ch.out_kind);
			seen_result.data = res_ch.out_byte;
			seen_result.offset = res_ch.out_offset;
			seen_result.status = rwcp_pkg::status_t'(res_ch.out_status);
			seen_result.done = res_ch.out_done;
			sb.check_result(seen_result);
		end
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		wav_ch.valid = 1'b0;
		wav_ch.in_byte = 8'h00;
		wav_ch.in_last = 1'b0;
		res_ch.ready = 1'b0;
		arst_n = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		cycle_count = 0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wrong riff magic: "RIFX"
		file_bytes.delete();
		put_tag(rwcp_pkg::MAGIC_RIFF ^ 32'h0000_001e);
		send_file();
		// file ends inside the riff magic
		file_bytes.delete();
		put_byte(rwcp_pkg::MAGIC_RIFF[31:24]);
		put_byte(rwcp_pkg::MAGIC_RIFF[23:16]);
		send_file();
		// good riff, wrong wave magic: "WAVF"
		file_bytes.delete();
		put_tag(rwcp_pkg::MAGIC_RIFF);
		put_size(32'h00ff_00ff);
		put_tag(rwcp_pkg::MAGIC_WAVE ^ 32'h0000_0003);
		send_file();
		// file ends inside the riff size, with all-ones and all-zeros bytes
		file_bytes.delete();
		put_tag(rwcp_pkg::MAGIC_RIFF);
		put_byte(8'hff);
		put_byte(8'h00);
		send_file();

		// random files under four idling regimes: none, sender, receiver, both
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 81;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 81;
				end
				default: begin
					idle_pct = 35;
					stall_pct = 35;
				end
			endcase
			while (items_sent < (p + 1) * PHASE_ITEMS) begin
				build_wave_file();
				send_file();
			end
		end

		@(negedge clk);
		wav_ch.valid <= 1'b0;

		// drain, then give the two-stage pipeline time to show any extra result
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (sb.failures == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
